### design/ufc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufc_pkg: shared types and constants of the frame checker
// Frame layout constants, status codes, queue entry and result item types,
// and the byte-wise CRC-16/CCITT update.
// ----------------------------------------------------------------------------
package ufc_pkg;

   localparam int unsigned MAX_FRAME_BYTES_DEF = 255;
   localparam int unsigned QUEUE_DEPTH_DEF     = 4;
   // largest frame whose payload count still fits in eight bits
   localparam int unsigned PAYLOAD_LIMIT_FRAME = 264;

   localparam int unsigned LEN_FIELD_BYTES = 2;   // bytes 0..1
   localparam int unsigned BUS_END_INDEX   = 6;   // bus id is bytes 2..5
   localparam int unsigned ADDR_INDEX      = 6;
   localparam int unsigned OVERHEAD_BYTES  = 9;   // header, address and crc

   localparam logic [15:0] CRC_INIT = 16'hFFFF;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_TOO_SHORT = 2'd1,
      ST_LEN_ERR   = 2'd2,
      ST_CRC_ERR   = 2'd3
   } frame_status_type;

   typedef enum logic {
      KIND_PAYLOAD = 1'b0,
      KIND_STATUS  = 1'b1
   } item_kind_type;

   // one queue word: what a single received byte produces
   typedef struct packed {
      logic             has_pay;
      logic [7:0]       pay_byte;
      logic             has_stat;
      logic [31:0]      bus_ident;
      logic [7:0]       node_address;
      logic [7:0]       payload_count;
      frame_status_type frame_status;
   } queue_entry_type;

   typedef struct packed {
      item_kind_type    item_kind;
      logic [7:0]       payload_byte;
      logic [31:0]      bus_ident;
      logic [7:0]       node_address;
      logic [7:0]       payload_count;
      frame_status_type frame_status;
      logic             run_last;
   } rsp_item_type;

   // CRC-16/CCITT (poly 0x1021, msb first), one byte
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [7:0] x;
      x = crc[15:8] ^ b;
      x = x ^ (x >> 4);
      return {crc[7:0], 8'h00} ^ {x[3:0], 12'h000} ^ {3'b000, x, 5'b00000}
             ^ {8'h00, x};
   endfunction

endpackage

### design/ufc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufc_front: byte parser and checker
// Tracks the byte position, the running CRC and the header fields, and turns
// each accepted byte that carries delayed payload or ends a frame into one queue word.
// ----------------------------------------------------------------------------
module ufc_front
   import ufc_pkg::*;
#(
   parameter int unsigned MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            accept,
   input  logic [7:0]      rx_byte,
   input  logic            frame_end,
   output logic            entry_push,
   output queue_entry_type entry
);

   localparam int unsigned CAP =
      (MAX_FRAME_BYTES < PAYLOAD_LIMIT_FRAME) ? MAX_FRAME_BYTES : PAYLOAD_LIMIT_FRAME;
   localparam int unsigned IDX_W = $clog2(CAP + 2);

   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [15:0]      crc_ff, crc_in;
   logic [15:0]      len_ff, len_in;
   logic [31:0]      bus_ff, bus_in;
   logic [7:0]       addr_ff, addr_in;
   logic [7:0]       dly0_ff, dly1_ff;

   logic [15:0]      idx16;
   frame_status_type status;

   assign idx16 = 16'(idx_ff);

   always_comb begin
      crc_in  = (idx16 >= 16'(LEN_FIELD_BYTES)) ? crc_byte(crc_ff, dly1_ff) : crc_ff;
      len_in  = (idx16 < 16'(LEN_FIELD_BYTES)) ? {len_ff[7:0], rx_byte} : len_ff;
      bus_in  = bus_ff;
      addr_in = addr_ff;
      if (idx16 >= 16'(LEN_FIELD_BYTES) && idx16 < 16'(BUS_END_INDEX)) begin
         bus_in = {bus_ff[23:0], rx_byte};
      end
      if (idx16 == 16'(ADDR_INDEX)) begin
         addr_in = rx_byte;
      end
      if (frame_end && idx_ff == '0) begin
         idx_in = idx_ff;
      end else begin
         idx_in = (idx_ff <= IDX_W'(CAP)) ? idx_ff + 1'b1 : idx_ff;
      end
   end

   // check order: single byte, length, crc, short frame
   always_comb begin
      if (idx_ff == '0) begin
         status = ST_TOO_SHORT;
      end else if (idx_ff >= IDX_W'(CAP) || (idx16 - 16'd1) != len_in) begin
         status = ST_LEN_ERR;
      end else if ({dly0_ff, rx_byte} != crc_in) begin
         status = ST_CRC_ERR;
      end else if (idx16 < 16'(OVERHEAD_BYTES - 1)) begin
         status = ST_TOO_SHORT;
      end else begin
         status = ST_OK;
      end
   end

   always_comb begin
      entry.has_pay       = idx16 >= 16'(OVERHEAD_BYTES);
      entry.pay_byte      = dly1_ff;
      entry.has_stat      = frame_end;
      entry.frame_status  = status;
      entry.bus_ident     = (status == ST_OK) ? bus_ff  : '0;
      entry.node_address  = (status == ST_OK) ? addr_ff : '0;
      entry.payload_count = (status == ST_OK) ? 8'(idx16 - 16'(OVERHEAD_BYTES - 1)) : '0;
      entry_push          = accept && (entry.has_pay || frame_end);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
         crc_ff <= CRC_INIT;
      end else if (accept) begin
         if (frame_end) begin
            idx_ff <= '0;
            crc_ff <= CRC_INIT;
         end else begin
            idx_ff <= idx_in;
            crc_ff <= crc_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         len_ff  <= len_in;
         bus_ff  <= bus_in;
         addr_ff <= addr_in;
         dly0_ff <= rx_byte;
         dly1_ff <= dly0_ff;
      end
   end

`ifndef SYNTHESIS
   // byte counter saturates one above the cap
   a_idx_cap: assert property (@(posedge clock) disable iff (reset)
      idx_ff <= IDX_W'(CAP + 1))
      else $error("ufc_front: byte index past saturation");
`endif

endmodule

### design/ufc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufc_queue: short word queue between front and back
// Circular buffer with a fill count; head word is shown while not empty.
// ----------------------------------------------------------------------------
module ufc_queue
   import ufc_pkg::*;
#(
   parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            wr_en,
   input  queue_entry_type wr_data,
   output logic            q_full,
   input  logic            rd_en,
   output logic            rd_valid,
   output queue_entry_type rd_data
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   queue_entry_type  mem [DEPTH];
   logic [PTR_W-1:0] wptr_ff, rptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             do_wr, do_rd;

   assign q_full   = count_ff == CNT_W'(DEPTH);
   assign rd_valid = count_ff != '0;
   assign rd_data  = mem[rptr_ff];
   assign do_wr    = wr_en && !q_full;
   assign do_rd    = rd_en && rd_valid;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem[wptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (do_wr) wptr_ff <= ptr_next(wptr_ff);
         if (do_rd) rptr_ff <= ptr_next(rptr_ff);
         if (do_wr && !do_rd) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_rd && !do_wr) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

`ifndef SYNTHESIS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("ufc_queue: fill count above depth");
`endif

endmodule

### design/ufc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufc_back: result sequencer with output register
// Expands each queue word into a payload item, a status item, or both in
// that order, and holds the current result until it is popped.
// ----------------------------------------------------------------------------
module ufc_back
   import ufc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            q_valid,
   input  queue_entry_type q_entry,
   output logic            q_rd,
   input  logic            pop,
   output logic            empty,
   output rsp_item_type    rsp
);

   logic         out_vld_ff, out_vld_in;
   logic         pay_done_ff, pay_done_in;
   rsp_item_type out_ff, out_in;
   logic         load, emit_pay;

   assign load     = q_valid && (!out_vld_ff || pop);
   assign emit_pay = q_entry.has_pay && !pay_done_ff;
   assign q_rd     = load && !(emit_pay && q_entry.has_stat);
   assign empty    = !out_vld_ff;
   assign rsp      = out_ff;

   always_comb begin
      out_in.item_kind     = emit_pay ? KIND_PAYLOAD : KIND_STATUS;
      out_in.payload_byte  = emit_pay ? q_entry.pay_byte : '0;
      out_in.bus_ident     = emit_pay ? '0 : q_entry.bus_ident;
      out_in.node_address  = emit_pay ? '0 : q_entry.node_address;
      out_in.payload_count = emit_pay ? '0 : q_entry.payload_count;
      out_in.frame_status  = emit_pay ? ST_OK : q_entry.frame_status;
      out_in.run_last      = !emit_pay;
      if (load) begin
         out_vld_in  = 1'b1;
         pay_done_in = emit_pay && q_entry.has_stat;
      end else begin
         out_vld_in  = out_vld_ff && !pop;
         pay_done_in = pay_done_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         pay_done_ff <= 1'b0;
      end else begin
         out_vld_ff  <= out_vld_in;
         pay_done_ff <= pay_done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_ff <= out_in;
      end
   end

`ifndef SYNTHESIS
   // a half-served word stays at the head until its status goes out
   a_pay_done_head: assert property (@(posedge clock) disable iff (reset)
      pay_done_ff |-> (q_valid && q_entry.has_pay && q_entry.has_stat))
      else $error("ufc_back: split word lost from queue head");

   a_status_after_pay: assert property (@(posedge clock) disable iff (reset)
      (load && emit_pay && q_entry.has_stat) |=> (pay_done_ff && !q_rd ||
         pay_done_ff && q_rd && out_in.item_kind == KIND_STATUS))
      else $error("ufc_back: status item not next after payload");
`endif

endmodule

### design/udp_frame_checker_crc16_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// udp_frame_checker_crc16_unit: byte-serial frame checker with CRC-16/CCITT
// Path: a result reaches the rsp ports through the queue and then the output
//   register; a status item sharing a word with payload follows that payload item.
// Throughput: one byte per cycle while not full, one result per cycle; full rises only while
//   the front-to-back queue is full under a stalled consumer.
// Reset: synchronous; empties the queue and output register, restarts framing.
// ----------------------------------------------------------------------------
module udp_frame_checker_crc16_unit
   import ufc_pkg::*;
#(
   // frames longer than this report a length mismatch
   parameter int unsigned MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF,
   // words buffered between the parser and the result sequencer
   parameter int unsigned QUEUE_DEPTH     = QUEUE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // input side
   input  logic        push,
   output logic        full,
   input  logic [7:0]  req_rx_byte,
   input  logic        req_frame_end,
   // result side
   output logic        empty,
   input  logic        pop,
   output logic        rsp_item_kind,
   output logic [7:0]  rsp_payload_byte,
   output logic [31:0] rsp_bus_ident,
   output logic [7:0]  rsp_node_address,
   output logic [7:0]  rsp_payload_count,
   output logic [1:0]  rsp_frame_status,
   output logic        rsp_run_last
);

   // The front parses every byte in the cycle it is accepted: byte position,
   // CRC over the byte leaving the two-byte delay line, header capture, and at
   // the frame's last byte the full status decision. Its word goes into the
   // queue; the back drains the queue into a single output register, so a
   // stalled consumer only backs up the queue and never the parser directly.

   logic            q_full;
   logic            accept;
   logic            entry_push;
   queue_entry_type entry;
   logic            q_valid;
   logic            q_rd;
   queue_entry_type q_head;
   rsp_item_type    rsp;

   assign full   = q_full;
   assign accept = push && !q_full;

   ufc_front #(
      .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .rx_byte    (req_rx_byte),
      .frame_end  (req_frame_end),
      .entry_push (entry_push),
      .entry      (entry)
   );

   ufc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (entry_push),
      .wr_data  (entry),
      .q_full   (q_full),
      .rd_en    (q_rd),
      .rd_valid (q_valid),
      .rd_data  (q_head)
   );

   ufc_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_entry (q_head),
      .q_rd    (q_rd),
      .pop     (pop),
      .empty   (empty),
      .rsp     (rsp)
   );

   // result fields straight from the output register
   assign rsp_item_kind     = rsp.item_kind;
   assign rsp_payload_byte  = rsp.payload_byte;
   assign rsp_bus_ident     = rsp.bus_ident;
   assign rsp_node_address  = rsp.node_address;
   assign rsp_payload_count = rsp.payload_count;
   assign rsp_frame_status  = rsp.frame_status;
   assign rsp_run_last      = rsp.run_last;

endmodule
